// File: hdl/bsh_pkg.sv
package bsh_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int MAX_CH      = 8;
  localparam int SLOT_W      = $clog2(MAX_CH);
  localparam int POS_W       = 7;
  localparam int DIVIDE_MAX  = 128;
  localparam int DEPTH_W     = 5;
  localparam int DIVIDE_W    = 8;
  localparam int CHANS_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = $clog2(SAMPLE_W);

  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = DEPTH_W'(SAMPLE_W);
  localparam logic [DIVIDE_W-1:0] DIVIDE_RST = DIVIDE_W'(1);
  localparam logic [CHANS_W-1:0]  CHANS_RST  = CHANS_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_DEPTH = 2'd0,
    CFG_DIVIDE    = 2'd1,
    CFG_CHANNELS  = 2'd2
  } bsh_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_DIV,
    ST_DONE
  } bsh_state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]  bit_depth;
    logic [DIVIDE_W-1:0] divide;
    logic [CHANS_W-1:0]  channels;
  } bsh_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SLOT_W-1:0]          slot;
    logic                       fresh;
  } bsh_item_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bsh_back_st_t;

  // quantizer factor 2^(d-1)-1 with the depth clamped to 2..SAMPLE_W
  function automatic logic [SAMPLE_W-2:0] quant_factor(logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0] d;
    d = depth;
    if (d < DEPTH_W'(2)) d = DEPTH_W'(2);
    if (d > DEPTH_W'(SAMPLE_W)) d = DEPTH_W'(SAMPLE_W);
    return {(SAMPLE_W-1){1'b1}} >> (DEPTH_W'(SAMPLE_W) - d);
  endfunction

  function automatic logic [DIVIDE_W-1:0] divide_eff(logic [DIVIDE_W-1:0] divide);
    logic [DIVIDE_W-1:0] v;
    v = divide;
    if (v == '0) v = DIVIDE_W'(1);
    if (v > DIVIDE_W'(DIVIDE_MAX)) v = DIVIDE_W'(DIVIDE_MAX);
    return v;
  endfunction

  // last channel index of a frame, channel count clamped to 1..MAX_CH
  function automatic logic [SLOT_W-1:0] last_channel(logic [CHANS_W-1:0] channels);
    logic [CHANS_W-1:0] n;
    n = channels;
    if (n == '0) n = CHANS_W'(1);
    if (n > CHANS_W'(MAX_CH)) n = CHANS_W'(MAX_CH);
    return SLOT_W'(n - CHANS_W'(1));
  endfunction

endpackage

// File: hdl/bsh_ifs.sv
interface bsh_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsh_pkg::SAMPLE_W-1:0] sample_in;
  logic [bsh_pkg::SLOT_W-1:0]          channel;
  logic                                buffer_start;

  modport source (output valid, sample_in, channel, buffer_start, input ready);
  modport sink (input valid, sample_in, channel, buffer_start, output ready);
endinterface

interface bsh_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsh_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

interface bsh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsh_pkg::CFG_IDX_W-1:0]    index;
  logic [bsh_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/bsh_front.sv
module bsh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsh_in_if.sink             in_i,
  input  bsh_pkg::bsh_cfg_t  cfg_i,
  output logic               push_valid_o,
  output bsh_pkg::bsh_item_t push_item_o,
  input  logic               push_ready_i
);

  logic [bsh_pkg::POS_W-1:0] pos_q, pos_d, pos_cur;
  logic [bsh_pkg::POS_W:0]   pos_next;
  logic                      accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  assign pos_cur  = in_i.buffer_start ? '0 : pos_q;
  assign pos_next = {1'b0, pos_cur} + (bsh_pkg::POS_W+1)'(1);

  assign push_item_o.sample = in_i.sample_in;
  assign push_item_o.slot   = in_i.channel;
  assign push_item_o.fresh  = (pos_cur == '0);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = pos_cur;
      if (in_i.channel == bsh_pkg::last_channel(cfg_i.channels)) begin
        if (pos_next >= bsh_pkg::divide_eff(cfg_i.divide)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_next[bsh_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: hdl/bsh_queue.sv
module bsh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  bsh_pkg::bsh_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output bsh_pkg::bsh_item_t pop_item_o,
  input  logic               pop_i
);

  bsh_pkg::bsh_item_t mem_q [bsh_pkg::QUEUE_DEPTH];
  logic [bsh_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [bsh_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != bsh_pkg::QCNT_W'(bsh_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == bsh_pkg::QPTR_W'(bsh_pkg::QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == bsh_pkg::QPTR_W'(bsh_pkg::QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/bsh_back.sv
module bsh_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsh_pkg::bsh_cfg_t     cfg_i,
  input  logic                  pop_valid_i,
  input  bsh_pkg::bsh_item_t    pop_item_i,
  output bsh_pkg::bsh_back_st_t status_o,
  bsh_out_if.source             out_o
);

  localparam int SW     = bsh_pkg::SAMPLE_W;
  localparam int PROD_W = 2 * SW - 1;

  bsh_pkg::bsh_state_e state_q, state_d;

  logic [SW-2:0]   fq;
  logic [SW-1:0]   raw;
  logic            sign_q;
  logic [SW-1:0]   mag_q;
  logic [bsh_pkg::SLOT_W-1:0] slot_q;
  logic            fresh_q;
  logic [PROD_W-1:0] prod_q, rnd;
  logic [SW-1:0]   rem_q, sh_q, den, rem_d;
  logic [SW:0]     trial_shift, trial_sub;
  logic            qbit;
  logic [bsh_pkg::CNT_W-1:0] cnt_q;
  logic [SW-1:0]   crushed;
  logic [SW-1:0]   held_q [bsh_pkg::MAX_CH];
  logic            out_valid_q, out_valid_d;
  logic [SW-1:0]   out_data_q;
  logic            pop, fire, busy;

  assign fq  = bsh_pkg::quant_factor(cfg_i.bit_depth);
  assign raw = pop_item_i.sample;
  assign rnd = prod_q + (PROD_W'(1) << (SW - 2));
  assign den = {fq, 1'b0};

  // one restoring step of the rounding divide
  assign trial_shift = {rem_q, sh_q[SW-1]};
  assign trial_sub   = trial_shift - {1'b0, den};
  assign qbit        = !trial_sub[SW];
  assign rem_d       = qbit ? trial_sub[SW-1:0] : trial_shift[SW-1:0];

  // sign restore and saturation
  always_comb begin
    if (sign_q) begin
      crushed = ~sh_q + 1'b1;
    end else if (sh_q[SW-1]) begin
      crushed = {1'b0, {(SW-1){1'b1}}};
    end else begin
      crushed = sh_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsh_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_item_i.fresh ? bsh_pkg::ST_MUL : bsh_pkg::ST_DONE;
        end
      end
      bsh_pkg::ST_MUL:   state_d = bsh_pkg::ST_ROUND;
      bsh_pkg::ST_ROUND: state_d = bsh_pkg::ST_DIV;
      bsh_pkg::ST_DIV: begin
        if (cnt_q == bsh_pkg::CNT_W'(SW - 1)) state_d = bsh_pkg::ST_DONE;
      end
      bsh_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = bsh_pkg::ST_IDLE;
      end
      default: state_d = bsh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    fire = 1'b0;
    busy = 1'b1;
    case (state_q)
      bsh_pkg::ST_IDLE: begin
        pop  = pop_valid_i;
        busy = 1'b0;
      end
      bsh_pkg::ST_DONE: fire = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign status_o.busy = busy;
  assign status_o.pop  = pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsh_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bsh_pkg::MAX_CH; i++) held_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire && fresh_q) begin
        held_q[slot_q] <= crushed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sign_q  <= raw[SW-1];
      mag_q   <= raw[SW-1] ? (~raw + 1'b1) : raw;
      slot_q  <= pop_item_i.slot;
      fresh_q <= pop_item_i.fresh;
    end
    if (state_q == bsh_pkg::ST_MUL) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(fq);
    end
    if (state_q == bsh_pkg::ST_ROUND) begin
      rem_q <= rnd[PROD_W-1:SW-1];
      sh_q  <= {1'b0, fq};
      cnt_q <= '0;
    end
    if (state_q == bsh_pkg::ST_DIV) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[SW-2:0], qbit};
      cnt_q <= cnt_q + 1'b1;
    end
    if (fire) begin
      out_data_q <= fresh_q ? crushed : held_q[slot_q];
    end
  end

endmodule

// File: hdl/bitcrush_sample_hold.sv
// a fresh sample passes through the multiply, round, serial divide and done states; a held one goes straight to done
// the back end works on one word at a time, and a fresh word keeps it busy through the 24-step serial divider
// held words skip the divider; a 2-word queue lets the front accept while the back works
// reset: async active low; position 0, hold values 0, bit_depth 24, divide 1, channels 2
module bitcrush_sample_hold (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsh_in_if.sink    in_i,
  bsh_out_if.source out_o,
  bsh_cfg_if.sink   cfg_i
);

  bsh_pkg::bsh_cfg_t     cfg_q;
  bsh_pkg::bsh_item_t    push_item, pop_item;
  bsh_pkg::bsh_back_st_t back_st;
  logic push_valid, push_ready, pop_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth <= bsh_pkg::DEPTH_RST;
      cfg_q.divide    <= bsh_pkg::DIVIDE_RST;
      cfg_q.channels  <= bsh_pkg::CHANS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bsh_pkg::CFG_BIT_DEPTH: cfg_q.bit_depth <= cfg_i.data[bsh_pkg::DEPTH_W-1:0];
        bsh_pkg::CFG_DIVIDE:    cfg_q.divide    <= cfg_i.data[bsh_pkg::DIVIDE_W-1:0];
        bsh_pkg::CFG_CHANNELS:  cfg_q.channels  <= cfg_i.data[bsh_pkg::CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  bsh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  bsh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (back_st.pop)
  );

  bsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .status_o    (back_st),
    .out_o       (out_o)
  );

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.pop |-> pop_valid)
    else $error("back end popped an empty queue");

  a_start_is_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.buffer_start) |-> push_item.fresh)
    else $error("buffer start word not marked fresh");

  a_out_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(back_st.busy))
    else $error("output word appeared without back end work");

endmodule
